// File: sv/bpfl_pkg.sv
package bpfl_pkg;

	// Command codes on opcode
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_WALK    = 2'd2;

	// Result codes on status
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_NOT_USED = 2'd2;
	localparam logic [1:0] STAT_EMPTY    = 2'd3;

	// Sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_REL   = 2'd2;
	localparam logic [1:0] ST_WALK  = 2'd3;

	// Port widths fixed by the interface
	localparam int BLOCK_W   = 4;
	localparam int COUNT_W   = 5;
	localparam int HANDLE_PW = 32;

endpackage

// File: sv/bpfl_ram.sv
module bpfl_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/block_pool_fifo_list_unit.sv
// Block pool with a free stack and an in-use list kept in allocation order.
//
// Command channel: a command transfers at a rising edge with start high and
// busy low. opcode selects allocate (payload is stored with the new block),
// release (block_index names the block) or walk (list every block in use).
// Result channel: each result is shown for one cycle with done high; the
// receiver takes it at the edge that ends that cycle and cannot stall it.
// last marks the final result of a command.
//
// Timing: allocate writes the payload and links while reading the free
// link memory, then pops the free stack; release reads the link
// memories, then writes back the neighbors' links. The result appears
// in the cycle after that, while a new command may already transfer.
// Errors (pool full, block not in use, empty list) answer in the next
// cycle. A walk returns one result per cycle, paced by the next-link read.
//
// Reset: all blocks are free, the free stack pops from the highest index
// down, the in-use list is empty. No clearing pass is needed; the free
// links read their reset value through a written-flag per block.
module block_pool_fifo_list_unit
	import bpfl_pkg::*;
#(
	parameter int POOL_SIZE    = 16,
	parameter int HANDLE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           opcode,
	input  logic [HANDLE_PW-1:0] payload,
	input  logic [BLOCK_W-1:0]   block_index,
	output logic                 done,
	output logic [1:0]           status,
	output logic [BLOCK_W-1:0]   out_block,
	output logic [HANDLE_PW-1:0] out_payload,
	output logic [COUNT_W-1:0]   free_count,
	output logic                 last
);

	localparam int IW = $clog2(POOL_SIZE);
	localparam int LW = $clog2(POOL_SIZE + 1);
	localparam int PW = (HANDLE_WIDTH < HANDLE_PW) ? HANDLE_WIDTH : HANDLE_PW;
	localparam int XW = (LW > BLOCK_W) ? LW : BLOCK_W;
	localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);

	logic [1:0]          state_q;
	logic [LW-1:0]       free_head_q;
	logic [LW-1:0]       used_head_q;
	logic [LW-1:0]       used_tail_q;
	logic [LW-1:0]       free_total_q;
	logic [POOL_SIZE-1:0] in_use_q;
	logic [POOL_SIZE-1:0] fl_wr_q;
	logic [IW-1:0]       cur_q;

	logic                done_q;
	logic [1:0]          status_q;
	logic [BLOCK_W-1:0]  out_block_q;
	logic [HANDLE_PW-1:0] out_payload_q;
	logic [COUNT_W-1:0]  free_count_q;
	logic                last_q;

	// Memory ports
	logic          fl_we, un_we, up_we, pay_we;
	logic [IW-1:0] fl_waddr, un_waddr, up_waddr, pay_waddr;
	logic [LW-1:0] fl_wdata, un_wdata, up_wdata;
	logic [PW-1:0] pay_wdata;
	logic [IW-1:0] fl_raddr, un_raddr, up_raddr, pay_raddr;
	logic [LW-1:0] fl_rdata, un_rdata, up_rdata;
	logic [PW-1:0] pay_rdata;

	logic          accept;
	logic          head_nil, tail_nil, free_nil;
	logic [XW-1:0] idx_x;
	logic          idx_ok;
	logic [IW-1:0] idx_i;
	logic [IW-1:0] fh_i;
	logic [LW-1:0] free_next;
	logic [LW-1:0] rel_prev, rel_next;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign head_nil = (used_head_q >= NIL);
	assign tail_nil = (used_tail_q >= NIL);
	assign free_nil = (free_head_q >= NIL);
	assign fh_i     = IW'(free_head_q);
	assign idx_x    = XW'(block_index);
	assign idx_i    = IW'(idx_x);
	assign idx_ok   = (idx_x < XW'(POOL_SIZE)) && in_use_q[idx_i];

	// Free link of the popped block; unwritten entries hold their reset chain
	assign free_next = fl_wr_q[fh_i] ? fl_rdata
		: ((free_head_q == '0) ? NIL : free_head_q - LW'(1));

	// Neighbors of the released block; head and tail stand in for the null ends
	assign rel_prev = (LW'(cur_q) == used_head_q) ? NIL : up_rdata;
	assign rel_next = (LW'(cur_q) == used_tail_q) ? NIL : un_rdata;

	// Drive memory reads and writes for each step
	always_comb begin
		fl_we     = 1'b0;
		un_we     = 1'b0;
		up_we     = 1'b0;
		pay_we    = 1'b0;
		fl_waddr  = idx_i;
		fl_wdata  = free_head_q;
		un_waddr  = IW'(used_tail_q);
		un_wdata  = free_head_q;
		up_waddr  = fh_i;
		up_wdata  = used_tail_q;
		pay_waddr = fh_i;
		pay_wdata = PW'(payload);
		fl_raddr  = fh_i;
		un_raddr  = IW'(used_head_q);
		up_raddr  = idx_i;
		pay_raddr = IW'(used_head_q);
		case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_ALLOC && !free_nil) begin
					pay_we = 1'b1;
					up_we  = 1'b1;
					un_we  = !tail_nil;
				end else if (accept && opcode == OP_RELEASE && idx_ok) begin
					un_raddr = idx_i;
					fl_we    = 1'b1;
				end
			end
			ST_REL: begin
				un_we    = (rel_prev < NIL);
				un_waddr = IW'(rel_prev);
				un_wdata = rel_next;
				up_we    = (rel_next < NIL);
				up_waddr = IW'(rel_next);
				up_wdata = rel_prev;
			end
			ST_WALK: begin
				un_raddr  = IW'(un_rdata);
				pay_raddr = IW'(un_rdata);
			end
			default: begin
			end
		endcase
	end

	bpfl_ram #(.DEPTH(POOL_SIZE), .WIDTH(LW)) u_free_next (
		.clk   (clk),
		.we    (fl_we),
		.waddr (fl_waddr),
		.wdata (fl_wdata),
		.raddr (fl_raddr),
		.rdata (fl_rdata)
	);

	bpfl_ram #(.DEPTH(POOL_SIZE), .WIDTH(LW)) u_used_next (
		.clk   (clk),
		.we    (un_we),
		.waddr (un_waddr),
		.wdata (un_wdata),
		.raddr (un_raddr),
		.rdata (un_rdata)
	);

	bpfl_ram #(.DEPTH(POOL_SIZE), .WIDTH(LW)) u_used_prev (
		.clk   (clk),
		.we    (up_we),
		.waddr (up_waddr),
		.wdata (up_wdata),
		.raddr (up_raddr),
		.rdata (up_rdata)
	);

	bpfl_ram #(.DEPTH(POOL_SIZE), .WIDTH(PW)) u_payload (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (pay_wdata),
		.raddr (pay_raddr),
		.rdata (pay_rdata)
	);

	// Sequence commands and update list pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			free_head_q  <= LW'(POOL_SIZE - 1);
			used_head_q  <= NIL;
			used_tail_q  <= NIL;
			free_total_q <= NIL;
			in_use_q     <= '0;
			fl_wr_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_ALLOC: begin
								if (free_nil) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_ALLOC;
								end
							end
							OP_RELEASE: begin
								if (!idx_ok) begin
									done_q <= 1'b1;
								end else begin
									fl_wr_q[idx_i]  <= 1'b1;
									in_use_q[idx_i] <= 1'b0;
									free_head_q     <= LW'(idx_i);
									free_total_q    <= free_total_q + LW'(1);
									state_q         <= ST_REL;
								end
							end
							OP_WALK: begin
								if (head_nil) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ALLOC: begin
					free_head_q    <= free_next;
					used_tail_q    <= free_head_q;
					if (head_nil) begin
						used_head_q <= free_head_q;
					end
					in_use_q[fh_i] <= 1'b1;
					free_total_q   <= free_total_q - LW'(1);
					done_q         <= 1'b1;
					state_q        <= ST_IDLE;
				end
				ST_REL: begin
					if (rel_prev >= NIL) begin
						used_head_q <= rel_next;
					end
					if (rel_next >= NIL) begin
						used_tail_q <= rel_prev;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					done_q <= 1'b1;
					if (LW'(cur_q) == used_tail_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the block under work and load the result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (opcode == OP_RELEASE) begin
					cur_q <= idx_i;
				end else begin
					cur_q <= IW'(used_head_q);
				end
				out_block_q   <= '0;
				out_payload_q <= '0;
				last_q        <= 1'b1;
				free_count_q  <= COUNT_W'(free_total_q);
				case (opcode)
					OP_ALLOC:   status_q <= STAT_FULL;
					OP_RELEASE: begin
						status_q    <= STAT_NOT_USED;
						out_block_q <= block_index;
					end
					default:    status_q <= STAT_EMPTY;
				endcase
			end
			ST_ALLOC: begin
				status_q      <= STAT_OK;
				out_block_q   <= BLOCK_W'(free_head_q);
				out_payload_q <= '0;
				free_count_q  <= COUNT_W'(free_total_q - LW'(1));
				last_q        <= 1'b1;
			end
			ST_REL: begin
				status_q      <= STAT_OK;
				out_block_q   <= BLOCK_W'(cur_q);
				out_payload_q <= '0;
				free_count_q  <= COUNT_W'(free_total_q);
				last_q        <= 1'b1;
			end
			ST_WALK: begin
				status_q      <= STAT_OK;
				out_block_q   <= BLOCK_W'(cur_q);
				out_payload_q <= HANDLE_PW'(pay_rdata);
				free_count_q  <= COUNT_W'(free_total_q);
				last_q        <= (LW'(cur_q) == used_tail_q);
				cur_q         <= IW'(un_rdata);
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign status      = status_q;
	assign out_block   = out_block_q;
	assign out_payload = out_payload_q;
	assign free_count  = free_count_q;
	assign last        = last_q;

	// Every block is either free or in use
	a_block_count: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(in_use_q) + int'(free_total_q)) == POOL_SIZE)
		else $error("free count and in-use flags disagree");

	// Head and tail of the in-use list are null together
	a_list_ends: assert property (@(posedge clk) disable iff (!arst_n)
		head_nil == tail_nil)
		else $error("in-use list head and tail out of step");

	// A walk only visits blocks in use
	a_walk_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> in_use_q[cur_q])
		else $error("walk reached a free block");

	// A release write-back follows its read cycle
	a_release_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_RELEASE && idx_ok) |=> (state_q == ST_REL && !in_use_q[cur_q]))
		else $error("release did not enter write-back");

endmodule
